FILE: rtl/cclat_pkg.sv
// ----------------------------------------------------------------------------
// cclat_pkg
// Shared types, codes and defaults of the cyclic competition lattice step.
// ----------------------------------------------------------------------------
package cclat_pkg;

   localparam int DEF_MAX_ROWS     = 256;
   localparam int DEF_MAX_COLUMNS  = 256;
   localparam int DEF_TALLY_WIDTH  = 16;
   localparam int DEF_RANDOM_WIDTH = 16;

   localparam int CRD_W   = 9;
   localparam int POP_W   = 17;
   localparam int LIM_W   = 17;
   localparam int SHIFT_W = 4;
   localparam int CSR_AW  = 5;

   localparam logic [1:0] SPEC_EMPTY = 2'd3;

   typedef enum logic [1:0] {MODE_REACT, MODE_LOAD, MODE_READ, MODE_CLEAR} mode_type;
   typedef enum logic [1:0] {DIR_UP, DIR_RIGHT, DIR_DOWN, DIR_LEFT} dir_type;
   typedef enum logic [2:0] {
      EV_NONE, EV_SWAP, EV_PRED, EV_BIRTH, EV_SKIP, EV_LOAD, EV_READ, EV_CLEAR
   } event_type;
   typedef enum logic [2:0] {REG_ROWS, REG_COLS, REG_SHIFT, REG_SWAP, REG_PRED} reg_type;

   typedef struct packed {
      logic [CRD_W-1:0]   rows;
      logic [CRD_W-1:0]   cols;
      logic [SHIFT_W-1:0] shift;
      logic [LIM_W-1:0]   swap_limit;
      logic [LIM_W-1:0]   pred_limit;
   } cfg_type;

   typedef struct packed {
      mode_type         mode;
      logic             in_range;
      logic [CRD_W-1:0] x;
      logic [CRD_W-1:0] y;
      logic [CRD_W-1:0] nx;
      logic [CRD_W-1:0] ny;
      logic [CRD_W-1:0] bin_y;
      logic [CRD_W-1:0] bin_ny;
      logic             moved_col;
      logic             below_swap;
      logic             below_pred;
      logic [1:0]       lspec;
      logic [1:0]       qspec;
      logic [7:0]       qbin;
      logic             qvalid;
   } cmd_type;

endpackage

FILE: rtl/cclat_if.sv
// ----------------------------------------------------------------------------
// cclat request and response channels
// Valid/ready channels carrying one item or one result per beat.
// ----------------------------------------------------------------------------
interface cclat_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [7:0]  row;
   logic [7:0]  column;
   logic [1:0]  direction;
   logic [15:0] action_random;
   logic [1:0]  load_species;
   logic [1:0]  query_species;
   logic [7:0]  query_bin;
   modport source (output valid, mode, row, column, direction, action_random,
                   load_species, query_species, query_bin, input ready);
   modport sink   (input valid, mode, row, column, direction, action_random,
                   load_species, query_species, query_bin, output ready);
endinterface

interface cclat_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [16:0] pop_first;
   logic [16:0] pop_second;
   logic [16:0] pop_third;
   logic [15:0] deaths_read;
   logic [15:0] births_read;
   logic [15:0] diffusions_read;
   modport source (output valid, event_res, pop_first, pop_second, pop_third,
                   deaths_read, births_read, diffusions_read, input ready);
   modport sink   (input valid, event_res, pop_first, pop_second, pop_third,
                   deaths_read, births_read, diffusions_read, output ready);
endinterface

FILE: rtl/cclat_front.sv
// ----------------------------------------------------------------------------
// cclat_front
// Accept items, find the neighbor, classify the action band, queue the beat.
// ----------------------------------------------------------------------------
module cclat_front import cclat_pkg::*; #(
   parameter int MAX_COLUMNS  = DEF_MAX_COLUMNS,
   parameter int RANDOM_WIDTH = DEF_RANDOM_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    clear_busy,
   cclat_req_if.sink req_chan,
   output logic    q_valid,
   output cmd_type q_head,
   input  logic    q_pop
);

   localparam int QDEPTH = 2;
   localparam logic [15:0] RMASK =
      (RANDOM_WIDTH >= 16) ? 16'hFFFF : 16'((64'd1 << RANDOM_WIDTH) - 64'd1);

   cmd_type          entry_ff [QDEPTH];
   logic             wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   cmd_type          cmd;
   logic [CRD_W-1:0] x, y;
   logic [63:0]      rs, swap_lim, pred_lim;
   logic             push;

   always_comb begin
      x = {1'b0, req_chan.row};
      y = {1'b0, req_chan.column};
      cmd.mode     = mode_type'(req_chan.mode);
      cmd.in_range = (x < cfg.rows) && (y < cfg.cols);
      cmd.x  = x;
      cmd.y  = y;
      cmd.nx = x;
      cmd.ny = y;
      case (dir_type'(req_chan.direction))
         DIR_UP:    cmd.nx = (x == '0) ? cfg.rows - 1'b1 : x - 1'b1;
         DIR_RIGHT: cmd.ny = (y + 1'b1 >= cfg.cols) ? '0 : y + 1'b1;
         DIR_DOWN:  cmd.nx = (x + 1'b1 >= cfg.rows) ? '0 : x + 1'b1;
         default:   cmd.ny = (y == '0) ? cfg.cols - 1'b1 : y - 1'b1;
      endcase
      cmd.bin_y     = cmd.y >> cfg.shift;
      cmd.bin_ny    = cmd.ny >> cfg.shift;
      cmd.moved_col = cmd.ny != cmd.y;
      rs       = {32'd0, req_chan.action_random & RMASK, 16'd0};
      swap_lim = 64'(cfg.swap_limit) << RANDOM_WIDTH;
      pred_lim = 64'(cfg.pred_limit) << RANDOM_WIDTH;
      cmd.below_swap = rs < swap_lim;
      cmd.below_pred = rs < pred_lim;
      cmd.lspec  = req_chan.load_species;
      cmd.qspec  = req_chan.query_species;
      cmd.qbin   = req_chan.query_bin;
      cmd.qvalid = (req_chan.query_species != SPEC_EMPTY) &&
                   (32'(req_chan.query_bin) < MAX_COLUMNS);
   end

   assign req_chan.ready = (count_ff != 2'(QDEPTH)) && !clear_busy;
   assign push    = req_chan.valid && req_chan.ready;
   assign q_valid = count_ff != '0;
   assign q_head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

FILE: rtl/cclat_back.sv
// ----------------------------------------------------------------------------
// cclat_back
// Carry out queued items against the lattice and tally memories.
// ----------------------------------------------------------------------------
module cclat_back import cclat_pkg::*; #(
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int TALLY_WIDTH = DEF_TALLY_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cmd_type q_head,
   output logic    q_pop,
   output logic    clear_busy,
   cclat_rsp_if.source rsp_chan
);

   localparam int SITES = MAX_ROWS * MAX_COLUMNS;
   localparam int AW    = $clog2(SITES);
   localparam int TD    = 3 * MAX_COLUMNS;
   localparam int TAW   = $clog2(TD);
   localparam int TW    = TALLY_WIDTH;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_DECIDE, ST_SITE2, ST_TRD, ST_TWR, ST_RESP
   } state_type;
   typedef enum logic [1:0] {K_DEATH, K_BIRTH, K_DIFF} kind_type;

   logic [1:0]      lat_mem [SITES];
   logic [3*TW-1:0] tal_mem [TD];

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [1:0]       lat_a_ff, lat_b_ff;
   logic [3*TW-1:0]  tal_rd_ff;
   logic [POP_W-1:0] pop_ff [3];
   logic [POP_W-1:0] pop_in [3];
   logic [TAW-1:0]   clr_idx_ff, clr_idx_in;
   logic             clr_item_ff, clr_item_in;
   logic [AW-1:0]    wr2_addr_ff, wr2_addr_in;
   logic [1:0]       wr2_data_ff, wr2_data_in;
   logic             tgo_ff, tgo_in;
   kind_type         t0_kind_ff, t0_kind_in;
   logic [TAW-1:0]   t0_addr_ff, t0_addr_in;
   logic             t1_valid_ff, t1_valid_in;
   logic [TAW-1:0]   t1_addr_ff, t1_addr_in;
   event_type        ev_ff, ev_in;
   logic [TW-1:0]    rd_d_ff, rd_d_in, rd_b_ff, rd_b_in, rd_f_ff, rd_f_in;
   logic             rsp_valid_ff, rsp_valid_in;
   event_type        o_ev_ff, o_ev_in;
   logic [POP_W-1:0] o_pop_ff [3];
   logic [POP_W-1:0] o_pop_in [3];
   logic [TW-1:0]    o_d_ff, o_d_in, o_b_ff, o_b_in, o_f_ff, o_f_in;

   logic            lat_we, tal_we;
   logic [AW-1:0]   lat_waddr, lat_ra, lat_rb, ci, ni;
   logic [1:0]      lat_wdata, cur, nb, nxt;
   logic [TAW-1:0]  tal_waddr, tal_ra;
   logic [3*TW-1:0] tal_wdata;
   logic [TW-1:0]   fld;

   function automatic logic [AW-1:0] site_addr(input logic [CRD_W-1:0] cx,
                                               input logic [CRD_W-1:0] cy);
      site_addr = AW'(32'(cx) * MAX_COLUMNS + 32'(cy));
   endfunction

   function automatic logic [TAW-1:0] tal_addr(input logic [1:0] spec,
                                               input logic [CRD_W-1:0] bin);
      tal_addr = TAW'(32'(spec) * MAX_COLUMNS + 32'(bin));
   endfunction

   function automatic logic [POP_W-1:0] pdec(input logic [POP_W-1:0] p);
      pdec = (p == '0) ? p : p - 1'b1;
   endfunction

   function automatic logic [POP_W-1:0] pinc(input logic [POP_W-1:0] p);
      pinc = (p == '1) ? p : p + 1'b1;
   endfunction

   function automatic logic [TW-1:0] sat(input logic [TW-1:0] t);
      sat = (t == '1) ? t : t + 1'b1;
   endfunction

   assign clear_busy = state_ff == ST_CLEAR;
   assign cur = lat_a_ff;
   assign nb  = lat_b_ff;
   assign nxt = (cur == 2'd2) ? 2'd0 : cur + 1'b1;
   assign ci  = site_addr(cmd_ff.x, cmd_ff.y);
   assign ni  = site_addr(cmd_ff.nx, cmd_ff.ny);

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      clr_idx_in  = clr_idx_ff;
      clr_item_in = clr_item_ff;
      wr2_addr_in = wr2_addr_ff;
      wr2_data_in = wr2_data_ff;
      tgo_in      = tgo_ff;
      t0_kind_in  = t0_kind_ff;
      t0_addr_in  = t0_addr_ff;
      t1_valid_in = t1_valid_ff;
      t1_addr_in  = t1_addr_ff;
      ev_in       = ev_ff;
      rd_d_in     = rd_d_ff;
      rd_b_in     = rd_b_ff;
      rd_f_in     = rd_f_ff;
      o_ev_in     = o_ev_ff;
      o_d_in      = o_d_ff;
      o_b_in      = o_b_ff;
      o_f_in      = o_f_ff;
      for (int s = 0; s < 3; s++) begin
         pop_in[s]   = pop_ff[s];
         o_pop_in[s] = o_pop_ff[s];
      end
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      q_pop     = 1'b0;
      lat_we    = 1'b0;
      lat_waddr = ni;
      lat_wdata = cur;
      lat_ra    = site_addr(q_head.x, q_head.y);
      lat_rb    = site_addr(q_head.nx, q_head.ny);
      tal_we    = 1'b0;
      tal_waddr = t0_addr_ff;
      tal_ra    = t0_addr_ff;
      tal_wdata = tal_rd_ff;
      fld       = '0;
      case (state_ff)
         ST_CLEAR: begin
            tal_we    = 1'b1;
            tal_waddr = clr_idx_ff;
            tal_wdata = '0;
            if (clr_idx_ff == TAW'(TD - 1)) begin
               clr_idx_in = '0;
               ev_in      = EV_CLEAR;
               state_in   = clr_item_ff ? ST_RESP : ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            tal_ra = tal_addr(q_head.qspec, CRD_W'(q_head.qbin));
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_head;
               rd_d_in  = '0;
               rd_b_in  = '0;
               rd_f_in  = '0;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_RESP;
            ev_in    = EV_NONE;
            case (cmd_ff.mode)
               MODE_REACT: begin
                  if (!cmd_ff.in_range) begin
                     ev_in = EV_NONE;
                  end else if (cur == SPEC_EMPTY) begin
                     ev_in = EV_SKIP;
                  end else if (cmd_ff.below_swap && nb != cur) begin
                     lat_we      = 1'b1;
                     wr2_addr_in = ci;
                     wr2_data_in = nb;
                     tgo_in      = cmd_ff.moved_col;
                     t0_kind_in  = K_DIFF;
                     t0_addr_in  = tal_addr(cur, cmd_ff.bin_y);
                     t1_valid_in = nb != SPEC_EMPTY;
                     t1_addr_in  = tal_addr(nb, cmd_ff.bin_ny);
                     ev_in       = EV_SWAP;
                     state_in    = ST_SITE2;
                  end else if (!cmd_ff.below_swap && cmd_ff.below_pred) begin
                     if (nb == nxt) begin
                        lat_we      = 1'b1;
                        lat_wdata   = SPEC_EMPTY;
                        pop_in[nb]  = pdec(pop_ff[nb]);
                        t0_kind_in  = K_DEATH;
                        t0_addr_in  = tal_addr(nb, cmd_ff.bin_ny);
                        t1_valid_in = 1'b0;
                        ev_in       = EV_PRED;
                        state_in    = ST_TRD;
                     end
                  end else if (!cmd_ff.below_pred && nb == SPEC_EMPTY) begin
                     lat_we      = 1'b1;
                     pop_in[cur] = pinc(pop_ff[cur]);
                     t0_kind_in  = K_BIRTH;
                     t0_addr_in  = tal_addr(cur, cmd_ff.bin_ny);
                     t1_valid_in = 1'b0;
                     ev_in       = EV_BIRTH;
                     state_in    = ST_TRD;
                  end
               end
               MODE_LOAD: begin
                  if (cmd_ff.in_range) begin
                     lat_we    = 1'b1;
                     lat_waddr = ci;
                     lat_wdata = cmd_ff.lspec;
                     for (int s = 0; s < 3; s++) begin
                        if (cur == 2'(s)) pop_in[s] = pdec(pop_ff[s]);
                        if (cmd_ff.lspec == 2'(s)) pop_in[s] = pinc(pop_in[s]);
                     end
                     ev_in = EV_LOAD;
                  end
               end
               MODE_READ: begin
                  if (cmd_ff.qvalid) begin
                     rd_d_in = tal_rd_ff[3*TW-1:2*TW];
                     rd_b_in = tal_rd_ff[2*TW-1:TW];
                     rd_f_in = tal_rd_ff[TW-1:0];
                  end
                  ev_in = EV_READ;
               end
               default: begin
                  clr_item_in = 1'b1;
                  state_in    = ST_CLEAR;
               end
            endcase
         end
         ST_SITE2: begin
            lat_we    = 1'b1;
            lat_waddr = wr2_addr_ff;
            lat_wdata = wr2_data_ff;
            state_in  = tgo_ff ? ST_TRD : ST_RESP;
         end
         ST_TRD: begin
            state_in = ST_TWR;
         end
         ST_TWR: begin
            tal_we = 1'b1;
            case (t0_kind_ff)
               K_DEATH: begin
                  fld = sat(tal_rd_ff[3*TW-1:2*TW]);
                  tal_wdata[3*TW-1:2*TW] = fld;
               end
               K_BIRTH: begin
                  fld = sat(tal_rd_ff[2*TW-1:TW]);
                  tal_wdata[2*TW-1:TW] = fld;
               end
               default: begin
                  fld = sat(tal_rd_ff[TW-1:0]);
                  tal_wdata[TW-1:0] = fld;
               end
            endcase
            if (t1_valid_ff) begin
               t0_kind_in  = K_DIFF;
               t0_addr_in  = t1_addr_ff;
               t1_valid_in = 1'b0;
               state_in    = ST_TRD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               o_ev_in      = ev_ff;
               for (int s = 0; s < 3; s++) o_pop_in[s] = pop_ff[s];
               o_d_in       = (ev_ff == EV_READ) ? rd_d_ff : '0;
               o_b_in       = (ev_ff == EV_READ) ? rd_b_ff : '0;
               o_f_in       = (ev_ff == EV_READ) ? rd_f_ff : '0;
               clr_item_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         clr_item_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < 3; s++) pop_ff[s] <= '0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         clr_item_ff  <= clr_item_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int s = 0; s < 3; s++) pop_ff[s] <= pop_in[s];
      end
      cmd_ff      <= cmd_in;
      wr2_addr_ff <= wr2_addr_in;
      wr2_data_ff <= wr2_data_in;
      tgo_ff      <= tgo_in;
      t0_kind_ff  <= t0_kind_in;
      t0_addr_ff  <= t0_addr_in;
      t1_valid_ff <= t1_valid_in;
      t1_addr_ff  <= t1_addr_in;
      ev_ff       <= ev_in;
      rd_d_ff     <= rd_d_in;
      rd_b_ff     <= rd_b_in;
      rd_f_ff     <= rd_f_in;
      o_ev_ff     <= o_ev_in;
      o_d_ff      <= o_d_in;
      o_b_ff      <= o_b_in;
      o_f_ff      <= o_f_in;
      for (int s = 0; s < 3; s++) o_pop_ff[s] <= o_pop_in[s];
   end

   always_ff @(posedge clock) begin
      if (lat_we) lat_mem[lat_waddr] <= lat_wdata;
      lat_a_ff <= lat_mem[lat_ra];
      lat_b_ff <= lat_mem[lat_rb];
   end

   always_ff @(posedge clock) begin
      if (tal_we) tal_mem[tal_waddr] <= tal_wdata;
      tal_rd_ff <= tal_mem[tal_ra];
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.event_res       = o_ev_ff;
   assign rsp_chan.pop_first       = o_pop_ff[0];
   assign rsp_chan.pop_second      = o_pop_ff[1];
   assign rsp_chan.pop_third       = o_pop_ff[2];
   assign rsp_chan.deaths_read     = 16'(o_d_ff);
   assign rsp_chan.births_read     = 16'(o_b_ff);
   assign rsp_chan.diffusions_read = 16'(o_f_ff);

endmodule

FILE: rtl/cyclic_competition_lattice_step.sv
// ----------------------------------------------------------------------------
// cyclic_competition_lattice_step
// Toroidal rock-paper-scissors lattice with population counts and bin tallies.
// ----------------------------------------------------------------------------
// Steps: skip, no change, load and read pass DECIDE and RESP; predation and
// birth pass DECIDE, TRD, TWR and RESP; a swap adds SITE2 for its second
// lattice write and, if the column moved, TRD/TWR tally updates, set by the
// single-write lattice and tally ports. Clear zeroes one tally entry a cycle.
// One item is worked at a time; a 2-beat queue holds items meanwhile. Reset:
// tally clear, no item accepted until it ends; lattice undefined until loaded.
module cyclic_competition_lattice_step import cclat_pkg::*; #(
   parameter int MAX_ROWS     = DEF_MAX_ROWS,
   parameter int MAX_COLUMNS  = DEF_MAX_COLUMNS,
   parameter int TALLY_WIDTH  = DEF_TALLY_WIDTH,
   parameter int RANDOM_WIDTH = DEF_RANDOM_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   cclat_req_if.sink         req_chan,
   cclat_rsp_if.source       rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   cfg_type          cfg_ff, cfg_in;
   logic             cfg_we, clear_busy, q_valid, q_pop;
   cmd_type          q_head;
   logic [CRD_W-1:0] rows_w, cols_w;
   reg_type          sel;

   function automatic logic [CRD_W-1:0] clamp(input logic [CRD_W-1:0] v, input int maxv);
      if (v == '0) clamp = CRD_W'(1);
      else if (32'(v) > maxv) clamp = CRD_W'(maxv);
      else clamp = v;
   endfunction

   assign csr_pready = 1'b1;
   assign cfg_we = csr_psel && csr_penable && csr_pwrite;
   assign sel    = reg_type'(csr_paddr[4:2]);
   assign rows_w = clamp(csr_pwdata[CRD_W-1:0], MAX_ROWS);
   assign cols_w = clamp(csr_pwdata[CRD_W-1:0], MAX_COLUMNS);

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_we) begin
         case (sel)
            REG_ROWS:  cfg_in.rows       = rows_w;
            REG_COLS:  cfg_in.cols       = cols_w;
            REG_SHIFT: cfg_in.shift      = csr_pwdata[SHIFT_W-1:0];
            REG_SWAP:  cfg_in.swap_limit = csr_pwdata[LIM_W-1:0];
            REG_PRED:  cfg_in.pred_limit = csr_pwdata[LIM_W-1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
      case (sel)
         REG_ROWS:  csr_prdata = 32'(cfg_ff.rows);
         REG_COLS:  csr_prdata = 32'(cfg_ff.cols);
         REG_SHIFT: csr_prdata = 32'(cfg_ff.shift);
         REG_SWAP:  csr_prdata = 32'(cfg_ff.swap_limit);
         REG_PRED:  csr_prdata = 32'(cfg_ff.pred_limit);
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows       <= clamp(CRD_W'(256), MAX_ROWS);
         cfg_ff.cols       <= clamp(CRD_W'(256), MAX_COLUMNS);
         cfg_ff.shift      <= SHIFT_W'(2);
         cfg_ff.swap_limit <= LIM_W'(25206);
         cfg_ff.pred_limit <= LIM_W'(45371);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cclat_front #(
      .MAX_COLUMNS  (MAX_COLUMNS),
      .RANDOM_WIDTH (RANDOM_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .clear_busy (clear_busy),
      .req_chan   (req_chan),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop)
   );

   cclat_back #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS),
      .TALLY_WIDTH (TALLY_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .clear_busy (clear_busy),
      .rsp_chan   (rsp_chan)
   );

endmodule

FILE: rtl/cclat_checker.sv
// ----------------------------------------------------------------------------
// cclat_checker
// Port-level checks of the lattice step, bound to the top level.
// ----------------------------------------------------------------------------
module cclat_checker import cclat_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  event_res,
   input logic [15:0] deaths_read,
   input logic [15:0] births_read,
   input logic [15:0] diffusions_read,
   input logic        req_ready,
   input logic        csr_pready
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid && !req_ready)
      else $error("channel active right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(event_res))
      else $error("stalled result beat changed");

   a_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && event_res != EV_READ |->
         deaths_read == '0 && births_read == '0 && diffusions_read == '0)
      else $error("tally fields set outside a read");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("config port stalled");

endmodule

bind cyclic_competition_lattice_step cclat_checker u_cclat_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .event_res       (rsp_chan.event_res),
   .deaths_read     (rsp_chan.deaths_read),
   .births_read     (rsp_chan.births_read),
   .diffusions_read (rsp_chan.diffusions_read),
   .req_ready       (req_chan.ready),
   .csr_pready      (csr_pready)
);

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cyclic competition lattice step testbench
// Drives load, reaction, tally read and tally clear beats into the lattice
// under random idling on both channels, predicts every result with its own
// lattice, population and tally model, and checks each result beat field by
// field. Runs through several register settings, extremes included.
// ----------------------------------------------------------------------------
module testbench;
   import cclat_pkg::*;

   localparam int IDLE_LIMIT  = 4000;
   localparam int PHASE_BEATS = 110;
   localparam int BIN_COUNT   = 256;
   localparam int TALLY_TOP   = 65535;
   localparam int POP_TOP     = 131071;
   localparam int KIND_DEATH  = 0;
   localparam int KIND_BIRTH  = 1;
   localparam int KIND_DIFF   = 2;

   typedef struct {
      mode_type    mode;
      logic [7:0]  row;
      logic [7:0]  column;
      dir_type     dir;
      logic [15:0] rnd;
      logic [1:0]  lspec;
      logic [1:0]  qspec;
      logic [7:0]  qbin;
   } lattice_item_t;

   typedef struct {
      event_type   ev;
      logic [16:0] p0;
      logic [16:0] p1;
      logic [16:0] p2;
      logic [15:0] dr;
      logic [15:0] br;
      logic [15:0] fr;
   } lattice_result_t;

   typedef struct {
      bit        typed;
      event_type ev;
   } typed_event_t;

   typedef struct {
      lattice_item_t item;
      bit            typed;
      event_type     ev;
   } directed_row_t;

   typedef struct {
      int unsigned rows, cols, shift, swap_lim, pred_lim;
   } setting_t;

   logic clock = 0;
   logic reset = 1;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   cclat_req_if req_bus();
   cclat_rsp_if rsp_bus();

   cyclic_competition_lattice_step dut (
      .clock(clock), .reset(reset), .req_chan(req_bus.sink), .rsp_chan(rsp_bus.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [1:0]  site_code [0:65535];
   bit          site_loaded [0:65535];
   int unsigned population [3];
   int unsigned tally [3][3*BIN_COUNT];
   int unsigned rows_cfg = 256, cols_cfg = 256, shift_cfg = 2;
   int unsigned swap_cfg = 25206, pred_cfg = 45371;

   lattice_result_t expected_results[$];
   typed_event_t    typed_events[$];
   int errors = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   bit hold_rsp = 0;

   initial begin
      req_bus.valid = 0;
      req_bus.mode = '0;
      req_bus.row = '0;
      req_bus.column = '0;
      req_bus.direction = '0;
      req_bus.action_random = '0;
      req_bus.load_species = '0;
      req_bus.query_species = '0;
      req_bus.query_bin = '0;
      rsp_bus.ready = 0;
      for (int i = 0; i < 65536; i++) begin
         site_code[i] = 2'd0;
         site_loaded[i] = 0;
      end
      for (int k = 0; k < 3; k++) begin
         population[k] = 0;
         for (int b = 0; b < 3*BIN_COUNT; b++) tally[k][b] = 0;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
   endtask

   function automatic void neighbour_of(input int unsigned x, input int unsigned y,
                                        input dir_type d, output int unsigned nx,
                                        output int unsigned ny);
      nx = x;
      ny = y;
      case (d)
         DIR_UP:    nx = (x == 0) ? rows_cfg - 1 : x - 1;
         DIR_RIGHT: ny = (y + 1 >= cols_cfg) ? 0 : y + 1;
         DIR_DOWN:  nx = (x + 1 >= rows_cfg) ? 0 : x + 1;
         default:   ny = (y == 0) ? cols_cfg - 1 : y - 1;
      endcase
   endfunction

   function automatic void bump_tally(input int kind, input int unsigned spec,
                                      input int unsigned col);
      int unsigned bin;
      bin = col >> shift_cfg;
      if (spec > 2 || bin >= BIN_COUNT) return;
      if (tally[kind][spec*BIN_COUNT + bin] < TALLY_TOP) tally[kind][spec*BIN_COUNT + bin]++;
   endfunction

   function automatic void pop_up(input int unsigned spec);
      if (spec < 3 && population[spec] < POP_TOP) population[spec]++;
   endfunction

   function automatic void pop_down(input int unsigned spec);
      if (spec < 3 && population[spec] > 0) population[spec]--;
   endfunction

   function automatic event_type react_at(input lattice_item_t it);
      int unsigned x, y, nx, ny, ci, ni, cur, nb;
      bit below_swap, below_pred;
      x = it.row;
      y = it.column;
      neighbour_of(x, y, it.dir, nx, ny);
      ci = x*256 + y;
      ni = nx*256 + ny;
      cur = site_code[ci];
      nb = site_code[ni];
      if (cur == SPEC_EMPTY) return EV_SKIP;
      below_swap = it.rnd < swap_cfg;
      below_pred = it.rnd < pred_cfg;
      if (below_swap && nb != cur) begin
         site_code[ni] = cur[1:0];
         site_code[ci] = nb[1:0];
         if (ny != y) begin
            bump_tally(KIND_DIFF, cur, y);
            if (nb != SPEC_EMPTY) bump_tally(KIND_DIFF, nb, ny);
         end
         return EV_SWAP;
      end
      if (!below_swap && below_pred) begin
         if (nb == (cur + 1) % 3) begin
            pop_down(nb);
            site_code[ni] = SPEC_EMPTY;
            bump_tally(KIND_DEATH, nb, ny);
            return EV_PRED;
         end
         return EV_NONE;
      end
      if (!below_pred && nb == SPEC_EMPTY) begin
         site_code[ni] = cur[1:0];
         pop_up(cur);
         bump_tally(KIND_BIRTH, cur, ny);
         return EV_BIRTH;
      end
      return EV_NONE;
   endfunction

   function automatic lattice_result_t advance_lattice(input lattice_item_t it);
      lattice_result_t res;
      bit in_grid;
      int unsigned idx;
      res = '{ev: EV_NONE, p0: 0, p1: 0, p2: 0, dr: 0, br: 0, fr: 0};
      in_grid = it.row < rows_cfg && it.column < cols_cfg;
      idx = it.row*256 + it.column;
      case (it.mode)
         MODE_REACT: if (in_grid) res.ev = react_at(it);
         MODE_LOAD: begin
            if (in_grid) begin
               pop_down(site_code[idx]);
               site_code[idx] = it.lspec;
               pop_up(it.lspec);
               res.ev = EV_LOAD;
            end
         end
         MODE_READ: begin
            if (it.qspec < 3) begin
               res.dr = 16'(tally[KIND_DEATH][it.qspec*BIN_COUNT + it.qbin]);
               res.br = 16'(tally[KIND_BIRTH][it.qspec*BIN_COUNT + it.qbin]);
               res.fr = 16'(tally[KIND_DIFF][it.qspec*BIN_COUNT + it.qbin]);
            end
            res.ev = EV_READ;
         end
         default: begin
            for (int k = 0; k < 3; k++)
               for (int b = 0; b < 3*BIN_COUNT; b++) tally[k][b] = 0;
            res.ev = EV_CLEAR;
         end
      endcase
      res.p0 = 17'(population[0]);
      res.p1 = 17'(population[1]);
      res.p2 = 17'(population[2]);
      return res;
   endfunction

   // never let the block read a lattice site that was never loaded
   function automatic bit item_legal(input lattice_item_t it);
      int unsigned nx, ny;
      if (it.row >= rows_cfg || it.column >= cols_cfg) return 1;
      if (it.mode == MODE_LOAD) return site_loaded[it.row*256 + it.column];
      if (it.mode != MODE_REACT) return 1;
      neighbour_of(it.row, it.column, it.dir, nx, ny);
      return site_loaded[it.row*256 + it.column] && site_loaded[nx*256 + ny];
   endfunction

   function automatic logic [7:0] pick_coord();
      int w;
      w = $urandom_range(0, 9);
      if (w < 8) return 8'($urandom_range(0, 7));
      if (w == 8) return 8'($urandom_range(0, 255));
      return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
   endfunction

   function automatic lattice_item_t pick_item();
      lattice_item_t it;
      int k;
      do begin
         k = $urandom_range(0, 99);
         it.mode = (k < 62) ? MODE_REACT : (k < 80) ? MODE_LOAD :
                   (k < 97) ? MODE_READ : MODE_CLEAR;
         it.row = pick_coord();
         it.column = pick_coord();
         it.dir = dir_type'($urandom_range(0, 3));
         k = $urandom_range(0, 9);
         it.rnd = (k == 0) ? 16'd0 : (k == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
         it.lspec = 2'($urandom_range(0, 3));
         it.qspec = 2'($urandom_range(0, 3));
         it.qbin = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7))
                                               : 8'($urandom_range(0, 255));
      end while (!item_legal(it));
      return it;
   endfunction

   task automatic send_item(input lattice_item_t it, input bit typed, input event_type ev);
      @(negedge clock);
      if (burst_left == 0) begin
         req_bus.valid = 0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
         @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      if (it.mode == MODE_LOAD && it.row < rows_cfg && it.column < cols_cfg)
         site_loaded[it.row*256 + it.column] = 1;
      req_bus.mode = it.mode;
      req_bus.row = it.row;
      req_bus.column = it.column;
      req_bus.direction = it.dir;
      req_bus.action_random = it.rnd;
      req_bus.load_species = it.lspec;
      req_bus.query_species = it.qspec;
      req_bus.query_bin = it.qbin;
      req_bus.valid = 1;
      typed_events.push_back('{typed: typed, ev: ev});
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid = 0;
      burst_left = 0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic program_reg(input reg_type idx, input int unsigned value);
      @(negedge clock);
      csr_psel = 1;
      csr_pwrite = 1;
      csr_penable = 0;
      csr_paddr = CSR_AW'(idx) << 2;
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      case (idx)
         REG_ROWS:  rows_cfg = ((value & 'h1FF) == 0) ? 1 : ((value & 'h1FF) > 256) ? 256
                               : (value & 'h1FF);
         REG_COLS:  cols_cfg = ((value & 'h1FF) == 0) ? 1 : ((value & 'h1FF) > 256) ? 256
                               : (value & 'h1FF);
         REG_SHIFT: shift_cfg = value & 'hF;
         REG_SWAP:  swap_cfg = value & 'h1FFFF;
         default:   pred_cfg = value & 'h1FFFF;
      endcase
   endtask

   // result side: stretches of ready and stall, plus one long hold-off on request
   initial begin
      int stretch;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 0;
            rsp_bus.ready = 0;
            stretch = 0;
            while (stretch < 300) begin
               @(negedge clock);
               stretch++;
            end
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_bus.ready = 0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end else begin
            rsp_bus.ready = 1;
            repeat ($urandom_range(0, 30)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      lattice_item_t it;
      lattice_result_t want, got;
      typed_event_t te;
      bit moved;
      moved = 0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            it.mode = mode_type'(req_bus.mode);
            it.row = req_bus.row;
            it.column = req_bus.column;
            it.dir = dir_type'(req_bus.direction);
            it.rnd = req_bus.action_random;
            it.lspec = req_bus.load_species;
            it.qspec = req_bus.query_species;
            it.qbin = req_bus.query_bin;
            want = advance_lattice(it);
            te = typed_events.pop_front();
            if (te.typed) want.ev = te.ev;
            expected_results.push_back(want);
            moved = 1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1;
            got.ev = event_type'(rsp_bus.event_res);
            got.p0 = rsp_bus.pop_first;
            got.p1 = rsp_bus.pop_second;
            got.p2 = rsp_bus.pop_third;
            got.dr = rsp_bus.deaths_read;
            got.br = rsp_bus.births_read;
            got.fr = rsp_bus.diffusions_read;
            if (expected_results.size() == 0) begin
               report_mismatch("result beat with nothing expected");
            end else begin
               want = expected_results.pop_front();
               if (got.ev !== want.ev)
                  report_mismatch($sformatf("event %0d, want %0d", got.ev, want.ev));
               if (got.p0 !== want.p0)
                  report_mismatch($sformatf("pop_first %0d, want %0d", got.p0, want.p0));
               if (got.p1 !== want.p1)
                  report_mismatch($sformatf("pop_second %0d, want %0d", got.p1, want.p1));
               if (got.p2 !== want.p2)
                  report_mismatch($sformatf("pop_third %0d, want %0d", got.p2, want.p2));
               if (got.dr !== want.dr)
                  report_mismatch($sformatf("deaths_read %0d, want %0d", got.dr, want.dr));
               if (got.br !== want.br)
                  report_mismatch($sformatf("births_read %0d, want %0d", got.br, want.br));
               if (got.fr !== want.fr)
                  report_mismatch($sformatf("diffusions_read %0d, want %0d", got.fr, want.fr));
            end
         end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("stalled for %0d cycles", IDLE_LIMIT);
         $display("[cyclic_competition_lattice_step] ERROR");
         $finish;
      end
   end

   directed_row_t directed_rows[] = '{
      '{'{MODE_READ,  8'd0,   8'd0,   DIR_UP,    16'd0,     2'd0, 2'd0, 8'd0},   1, EV_READ},
      '{'{MODE_READ,  8'd0,   8'd0,   DIR_UP,    16'd0,     2'd0, 2'd3, 8'd255}, 1, EV_READ},
      '{'{MODE_LOAD,  8'd0,   8'd0,   DIR_UP,    16'd0,     2'd0, 2'd0, 8'd0},   1, EV_LOAD},
      '{'{MODE_LOAD,  8'd0,   8'd1,   DIR_UP,    16'd0,     2'd1, 2'd0, 8'd0},   1, EV_LOAD},
      '{'{MODE_LOAD,  8'd1,   8'd0,   DIR_UP,    16'd0,     2'd2, 2'd0, 8'd0},   1, EV_LOAD},
      '{'{MODE_LOAD,  8'd255, 8'd255, DIR_UP,    16'd0,     2'd3, 2'd0, 8'd0},   1, EV_LOAD},
      '{'{MODE_LOAD,  8'd0,   8'd255, DIR_UP,    16'd0,     2'd2, 2'd0, 8'd0},   1, EV_LOAD},
      '{'{MODE_REACT, 8'd255, 8'd255, DIR_RIGHT, 16'd0,     2'd0, 2'd0, 8'd0},   1, EV_SKIP},
      '{'{MODE_REACT, 8'd0,   8'd0,   DIR_RIGHT, 16'd0,     2'd0, 2'd0, 8'd0},   0, EV_NONE},
      '{'{MODE_REACT, 8'd0,   8'd1,   DIR_LEFT,  16'hFFFF,  2'd0, 2'd0, 8'd0},   0, EV_NONE},
      '{'{MODE_REACT, 8'd0,   8'd0,   DIR_UP,    16'hFFFF,  2'd0, 2'd0, 8'd0},   0, EV_NONE},
      '{'{MODE_REACT, 8'd0,   8'd1,   DIR_LEFT,  16'd30000, 2'd0, 2'd0, 8'd0},   0, EV_NONE},
      '{'{MODE_REACT, 8'd0,   8'd0,   DIR_LEFT,  16'd0,     2'd0, 2'd0, 8'd0},   1, EV_SKIP},
      '{'{MODE_LOAD,  8'd0,   8'd0,   DIR_UP,    16'd0,     2'd1, 2'd0, 8'd0},   1, EV_LOAD},
      '{'{MODE_REACT, 8'd0,   8'd0,   DIR_LEFT,  16'd0,     2'd0, 2'd0, 8'd0},   0, EV_NONE},
      '{'{MODE_REACT, 8'd255, 8'd0,   DIR_DOWN,  16'hFFFF,  2'd0, 2'd0, 8'd0},   0, EV_NONE},
      '{'{MODE_REACT, 8'd0,   8'd1,   DIR_RIGHT, 16'd45370, 2'd0, 2'd0, 8'd0},   0, EV_NONE},
      '{'{MODE_REACT, 8'd0,   8'd1,   DIR_RIGHT, 16'd45371, 2'd0, 2'd0, 8'd0},   0, EV_NONE},
      '{'{MODE_REACT, 8'd0,   8'd2,   DIR_DOWN,  16'd25205, 2'd0, 2'd0, 8'd0},   0, EV_NONE},
      '{'{MODE_READ,  8'd0,   8'd0,   DIR_UP,    16'd0,     2'd0, 2'd1, 8'd0},   0, EV_NONE},
      '{'{MODE_READ,  8'd0,   8'd0,   DIR_UP,    16'd0,     2'd0, 2'd2, 8'd63},  0, EV_NONE},
      '{'{MODE_CLEAR, 8'd0,   8'd0,   DIR_UP,    16'd0,     2'd0, 2'd0, 8'd0},   1, EV_CLEAR},
      '{'{MODE_READ,  8'd0,   8'd0,   DIR_UP,    16'd0,     2'd0, 2'd2, 8'd63},  1, EV_READ}
   };

   setting_t settings[] = '{
      '{8, 8, 0, 25206, 45371},
      '{0, 511, 15, 0, 65536},
      '{5, 3, 8, 65536, 65536},
      '{511, 0, 1, 131071, 0},
      '{8, 8, 2, 20000, 40000},
      '{256, 256, 4, 30000, 50000}
   };

   initial begin
      lattice_item_t fill;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // load every site in use as empty while all populations are still zero
      fill = '{MODE_LOAD, 8'd0, 8'd0, DIR_UP, 16'd0, SPEC_EMPTY, 2'd0, 8'd0};
      for (int r = 0; r < 8; r++)
         for (int c = 0; c < 8; c++) begin
            fill.row = 8'(r);
            fill.column = 8'(c);
            send_item(fill, 1, EV_LOAD);
         end
      fill.row = 255; fill.column = 255; send_item(fill, 1, EV_LOAD);
      fill.row = 0;   fill.column = 255; send_item(fill, 1, EV_LOAD);
      fill.row = 255; fill.column = 0;   send_item(fill, 1, EV_LOAD);

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].ev);
      drain_results();

      foreach (settings[p]) begin
         program_reg(REG_ROWS, settings[p].rows);
         program_reg(REG_COLS, settings[p].cols);
         program_reg(REG_SHIFT, settings[p].shift);
         program_reg(REG_SWAP, settings[p].swap_lim);
         program_reg(REG_PRED, settings[p].pred_lim);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (p == 0 && n == 20) hold_rsp = 1;
            if (p == 1 && n == 50) begin
               @(negedge clock);
               req_bus.valid = 0;
               burst_left = 0;
               while (expected_results.size() != 0) @(negedge clock);
            end
            send_item(pick_item(), 0, EV_NONE);
         end
         drain_results();
      end

      if (errors == 0) begin
         $display("[cyclic_competition_lattice_step] OK");
      end else begin
         $display("[cyclic_competition_lattice_step] ERROR");
      end
      $finish;
   end

endmodule
